// File: rtl/sfr_pkg.sv
`default_nettype none

package sfr_pkg;

    localparam logic [7:0]  CKSUM_NONE_CODE  = 8'd0;
    localparam logic [7:0]  CKSUM_XOR_CODE   = 8'd1;
    localparam logic [7:0]  CKSUM_CRC32_CODE = 8'd32;

    localparam logic [7:0]  START_BYTE      = 8'h01;
    localparam logic [2:0]  LEN_BYTES       = 3'd2;
    localparam logic [31:0] CRC_POLY        = 32'hEDB88320;
    localparam logic [15:0] MAX_PAYLOAD_RST = 16'd256;

    localparam int          CFG_INDEX_W     = 8;
    localparam int          CFG_DATA_W      = 16;
    localparam logic [CFG_INDEX_W-1:0] REG_RX_ENABLE   = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_PAYLOAD = 8'd1;

    typedef enum logic [2:0] {
        ST_OK,
        ST_DISABLED,
        ST_BAD_START,
        ST_EMPTY,
        ST_HXOR_BAD,
        ST_TOO_LONG,
        ST_CKSUM_BAD,
        ST_UNKNOWN_TYPE
    } status_t;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_TYPE,
        PH_LEN,
        PH_HXOR,
        PH_PAYLOAD,
        PH_DISCARD,
        PH_CHECK
    } phase_t;

    typedef struct packed {
        logic        rx_enable;
        logic [15:0] max_payload;
    } cfg_t;

    typedef struct packed {
        status_t     status;
        logic        payload_valid;
        logic [7:0]  payload_byte;
        logic        frame_end;
        logic        frame_good;
        logic [15:0] frame_length;
    } result_t;

    function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int i = 0; i < 8; i++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    function automatic logic type_known(input logic [7:0] t);
        return (t == CKSUM_NONE_CODE) || (t == CKSUM_XOR_CODE) || (t == CKSUM_CRC32_CODE);
    endfunction

    function automatic logic [2:0] check_bytes(input logic [7:0] t);
        logic [2:0] n;
        if (t == CKSUM_NONE_CODE)
        begin
            n = 3'd0;
        end
        else if (t == CKSUM_XOR_CODE)
        begin
            n = 3'd1;
        end
        else if (t == CKSUM_CRC32_CODE)
        begin
            n = 3'd4;
        end
        else
        begin
            n = 3'd0;
        end
        return n;
    endfunction

endpackage

`default_nettype wire

// File: rtl/serial_frame_receiver_top.sv
// A result passes through the input register and then the result register.
// One byte per cycle unless the result side stalls; parser state and byte-wide CRC-32 step per byte.
// Back-pressure on the result side stalls the input register, which still holds one byte.
// Reset (rst_n low, asynchronous): both registers empty, parser idle with cleared state,
// rx_enable 0 and max_payload 256. No clearing pass; the block is ready once reset is released.
`default_nettype none

module serial_frame_receiver_top (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             s_tvalid,
    output      logic                             s_tready,
    input  wire logic [7:0]                       s_tdata,   // [7:0] rx_byte
    output      logic                             m_tvalid,
    input  wire logic                             m_tready,
    output      logic [31:0]                      m_tdata,   // [2:0] status, [10:3] payload_byte,
                                                             // [11] frame_good,
                                                             // [27:12] frame_length, [31:28] zero
    output      logic                             m_tuser,   // [0] payload_valid
    output      logic                             m_tlast,   // frame_end
    input  wire logic                             cfg_valid,
    output      logic                             cfg_ready,
    input  wire logic [sfr_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [sfr_pkg::CFG_DATA_W-1:0]   cfg_data
);

    sfr_pkg::cfg_t    cfg;
    sfr_pkg::result_t res;

    logic             in_valid_reg;
    logic             in_valid_next;
    logic [7:0]       in_byte_reg;
    logic             out_valid_reg;
    logic             out_valid_next;
    sfr_pkg::result_t out_res_reg;
    logic             out_free;
    logic             fire;

    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || m_tready;
    assign fire      = in_valid_reg && out_free;
    assign s_tready  = !in_valid_reg || out_free;

    sfr_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    sfr_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (fire),
        .rx_byte (in_byte_reg),
        .cfg     (cfg),
        .res     (res)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_tready)
        begin
            in_valid_next = s_tvalid;
        end
        out_valid_next = out_valid_reg;
        if (out_free)
        begin
            out_valid_next = in_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg <= s_tdata;
        end
        if (fire)
        begin
            out_res_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, out_res_reg.frame_length, out_res_reg.frame_good,
                       out_res_reg.payload_byte, out_res_reg.status};
    assign m_tuser  = out_res_reg.payload_valid;
    assign m_tlast  = out_res_reg.frame_end;

endmodule

`default_nettype wire

// File: rtl/sfr_cfg.sv
`default_nettype none

module sfr_cfg (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_valid,
    input  wire logic [sfr_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [sfr_pkg::CFG_DATA_W-1:0]   cfg_data,
    output sfr_pkg::cfg_t                         cfg
);

    logic        rx_enable_reg;
    logic        rx_enable_next;
    logic [15:0] max_payload_reg;
    logic [15:0] max_payload_next;

    always_comb
    begin
        rx_enable_next   = rx_enable_reg;
        max_payload_next = max_payload_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                sfr_pkg::REG_RX_ENABLE:   rx_enable_next   = cfg_data[0];
                sfr_pkg::REG_MAX_PAYLOAD: max_payload_next = cfg_data[15:0];
                default:                  ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_enable_reg   <= 1'b0;
            max_payload_reg <= sfr_pkg::MAX_PAYLOAD_RST;
        end
        else
        begin
            rx_enable_reg   <= rx_enable_next;
            max_payload_reg <= max_payload_next;
        end
    end

    assign cfg.rx_enable   = rx_enable_reg;
    assign cfg.max_payload = max_payload_reg;

endmodule

`default_nettype wire

// File: rtl/sfr_parser.sv
`default_nettype none

module sfr_parser (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          step,
    input  wire logic [7:0]    rx_byte,
    input  wire sfr_pkg::cfg_t cfg,
    output sfr_pkg::result_t   res
);

    sfr_pkg::phase_t phase_reg;
    sfr_pkg::phase_t phase_next;
    logic [7:0]  header_xor_reg;
    logic [7:0]  header_xor_next;
    logic [7:0]  check_type_reg;
    logic [7:0]  check_type_next;
    logic [15:0] frame_len_reg;
    logic [15:0] frame_len_next;
    logic [16:0] byte_count_reg;
    logic [16:0] byte_count_next;
    logic [31:0] field_accum_reg;
    logic [31:0] field_accum_next;
    logic [2:0]  field_count_reg;
    logic [2:0]  field_count_next;
    logic [31:0] check_accum_reg;
    logic [31:0] check_accum_next;

    logic [16:0] cnt_inc;
    logic [16:0] chk_len;
    logic [2:0]  fc_inc;
    logic [31:0] len_accum;
    logic [15:0] len_value;
    logic        len_last;
    logic [31:0] chk_accum_new;
    logic        hxor_ok;
    logic        too_long;
    logic        pay_last;
    logic        check_last;
    logic        check_ok;
    logic [31:0] crc_next;
    logic        done;

    assign cnt_inc       = byte_count_reg + 17'd1;
    assign chk_len       = {1'b0, frame_len_reg}
                           + {14'd0, sfr_pkg::check_bytes(check_type_reg)};
    assign fc_inc        = field_count_reg + 3'd1;
    assign len_accum     = field_accum_reg | ({24'd0, rx_byte} << {field_count_reg[0], 3'b000});
    assign len_value     = len_accum[15:0];
    assign len_last      = (fc_inc == sfr_pkg::LEN_BYTES);
    assign chk_accum_new = field_accum_reg
                           | ({24'd0, rx_byte} << {field_count_reg[1:0], 3'b000});
    assign hxor_ok       = (header_xor_reg == rx_byte);
    assign too_long      = (frame_len_reg > cfg.max_payload);
    assign pay_last      = (cnt_inc >= {1'b0, frame_len_reg});
    assign check_last    = (fc_inc >= sfr_pkg::check_bytes(check_type_reg));
    assign check_ok      = (check_type_reg == sfr_pkg::CKSUM_XOR_CODE)
                           ? (chk_accum_new[7:0] == check_accum_reg[7:0])
                           : (chk_accum_new == ~check_accum_reg);
    assign crc_next      = sfr_pkg::crc32_byte(check_accum_reg, rx_byte);

    always_comb
    begin
        phase_next       = phase_reg;
        header_xor_next  = header_xor_reg;
        check_type_next  = check_type_reg;
        frame_len_next   = frame_len_reg;
        byte_count_next  = byte_count_reg;
        field_accum_next = field_accum_reg;
        field_count_next = field_count_reg;
        check_accum_next = check_accum_reg;
        done             = 1'b0;
        if (step && cfg.rx_enable)
        begin
            case (phase_reg)
                sfr_pkg::PH_IDLE:
                begin
                    if (rx_byte == sfr_pkg::START_BYTE)
                    begin
                        header_xor_next = header_xor_reg ^ rx_byte;
                        phase_next      = sfr_pkg::PH_TYPE;
                    end
                end
                sfr_pkg::PH_TYPE:
                begin
                    check_type_next  = rx_byte;
                    header_xor_next  = header_xor_reg ^ rx_byte;
                    field_accum_next = 32'd0;
                    field_count_next = 3'd0;
                    phase_next       = sfr_pkg::PH_LEN;
                end
                sfr_pkg::PH_LEN:
                begin
                    field_accum_next = len_accum;
                    field_count_next = fc_inc;
                    header_xor_next  = header_xor_reg ^ rx_byte;
                    if (len_last)
                    begin
                        frame_len_next = len_value;
                        if (len_value == 16'd0)
                        begin
                            done = 1'b1;
                        end
                        else
                        begin
                            phase_next = sfr_pkg::PH_HXOR;
                        end
                    end
                end
                sfr_pkg::PH_HXOR:
                begin
                    if (!hxor_ok || !sfr_pkg::type_known(check_type_reg))
                    begin
                        done = 1'b1;
                    end
                    else if (too_long)
                    begin
                        byte_count_next = 17'd0;
                        phase_next      = sfr_pkg::PH_DISCARD;
                    end
                    else
                    begin
                        byte_count_next  = 17'd0;
                        check_accum_next = (check_type_reg == sfr_pkg::CKSUM_XOR_CODE)
                                           ? 32'd0 : 32'hFFFF_FFFF;
                        phase_next       = sfr_pkg::PH_PAYLOAD;
                    end
                end
                sfr_pkg::PH_DISCARD:
                begin
                    byte_count_next = cnt_inc;
                    if (cnt_inc >= chk_len)
                    begin
                        done = 1'b1;
                    end
                end
                sfr_pkg::PH_PAYLOAD:
                begin
                    if (check_type_reg == sfr_pkg::CKSUM_XOR_CODE)
                    begin
                        check_accum_next = {24'd0, check_accum_reg[7:0] ^ rx_byte};
                    end
                    else if (check_type_reg == sfr_pkg::CKSUM_CRC32_CODE)
                    begin
                        check_accum_next = crc_next;
                    end
                    byte_count_next = cnt_inc;
                    if (pay_last)
                    begin
                        if (check_type_reg == sfr_pkg::CKSUM_NONE_CODE)
                        begin
                            done = 1'b1;
                        end
                        else
                        begin
                            field_accum_next = 32'd0;
                            field_count_next = 3'd0;
                            phase_next       = sfr_pkg::PH_CHECK;
                        end
                    end
                end
                sfr_pkg::PH_CHECK:
                begin
                    field_accum_next = chk_accum_new;
                    field_count_next = fc_inc;
                    if (check_last)
                    begin
                        done = 1'b1;
                    end
                end
                default:
                begin
                    done = 1'b1;
                end
            endcase
        end
        if (done)
        begin
            phase_next       = sfr_pkg::PH_IDLE;
            header_xor_next  = 8'd0;
            check_type_next  = sfr_pkg::CKSUM_NONE_CODE;
            frame_len_next   = 16'd0;
            byte_count_next  = 17'd0;
            field_accum_next = 32'd0;
            field_count_next = 3'd0;
            check_accum_next = 32'd0;
        end
    end

    always_comb
    begin
        res.status        = sfr_pkg::ST_OK;
        res.payload_valid = 1'b0;
        res.payload_byte  = 8'd0;
        res.frame_end     = 1'b0;
        res.frame_good    = 1'b0;
        res.frame_length  = (phase_reg == sfr_pkg::PH_LEN && len_last) ? len_value
                                                                       : frame_len_reg;
        if (!cfg.rx_enable)
        begin
            res.status       = sfr_pkg::ST_DISABLED;
            res.frame_length = 16'd0;
        end
        else
        begin
            case (phase_reg)
                sfr_pkg::PH_IDLE:
                begin
                    if (rx_byte != sfr_pkg::START_BYTE)
                    begin
                        res.status = sfr_pkg::ST_BAD_START;
                    end
                end
                sfr_pkg::PH_LEN:
                begin
                    if (len_last && len_value == 16'd0)
                    begin
                        res.status = sfr_pkg::ST_EMPTY;
                    end
                end
                sfr_pkg::PH_HXOR:
                begin
                    if (!hxor_ok)
                    begin
                        res.status = sfr_pkg::ST_HXOR_BAD;
                    end
                    else if (!sfr_pkg::type_known(check_type_reg))
                    begin
                        res.status = sfr_pkg::ST_UNKNOWN_TYPE;
                    end
                    else if (too_long)
                    begin
                        res.status = sfr_pkg::ST_TOO_LONG;
                    end
                end
                sfr_pkg::PH_PAYLOAD:
                begin
                    res.payload_valid = 1'b1;
                    res.payload_byte  = rx_byte;
                    if (pay_last && check_type_reg == sfr_pkg::CKSUM_NONE_CODE)
                    begin
                        res.frame_end  = 1'b1;
                        res.frame_good = 1'b1;
                    end
                end
                sfr_pkg::PH_CHECK:
                begin
                    if (check_last)
                    begin
                        res.frame_end  = 1'b1;
                        res.frame_good = check_ok;
                        res.status     = check_ok ? sfr_pkg::ST_OK : sfr_pkg::ST_CKSUM_BAD;
                    end
                end
                default:
                begin
                    res.status = sfr_pkg::ST_OK;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= sfr_pkg::PH_IDLE;
            header_xor_reg  <= 8'd0;
            check_type_reg  <= sfr_pkg::CKSUM_NONE_CODE;
            frame_len_reg   <= 16'd0;
            byte_count_reg  <= 17'd0;
            field_accum_reg <= 32'd0;
            field_count_reg <= 3'd0;
            check_accum_reg <= 32'd0;
        end
        else
        begin
            phase_reg       <= phase_next;
            header_xor_reg  <= header_xor_next;
            check_type_reg  <= check_type_next;
            frame_len_reg   <= frame_len_next;
            byte_count_reg  <= byte_count_next;
            field_accum_reg <= field_accum_next;
            field_count_reg <= field_count_next;
            check_accum_reg <= check_accum_next;
        end
    end

    a_end_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
        step && cfg.rx_enable && res.frame_end |=> phase_reg == sfr_pkg::PH_IDLE)
        else $error("frame end did not return parser to idle");

    a_disabled_holds: assert property (@(posedge clk) disable iff (!rst_n)
        step && !cfg.rx_enable |=> $stable(phase_reg) && $stable(byte_count_reg))
        else $error("parser state moved while receiver disabled");

    a_payload_count: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == sfr_pkg::PH_PAYLOAD |-> byte_count_reg < {1'b0, frame_len_reg})
        else $error("payload count reached frame length inside payload");

    a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == sfr_pkg::PH_HXOR || phase_reg == sfr_pkg::PH_PAYLOAD
         || phase_reg == sfr_pkg::PH_DISCARD) |-> frame_len_reg != 16'd0)
        else $error("zero frame length past header");

endmodule

`default_nettype wire
